// ----- hw/rtl/max_window_sum_2d_defines.svh -----
// ----------------------------------------------------------------------------
// max_window_sum_2d assertion macros
// Concurrent assertion helpers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef MAX_WINDOW_SUM_2D_DEFINES_SVH
`define MAX_WINDOW_SUM_2D_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check with synchronous active-low reset as disable
`define MWS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("max_window_sum_2d assertion failed");
// clocked check with no disable
`define MWS_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("max_window_sum_2d assertion failed");
`else
`define MWS_ASSERT(name, clk, rst_n, prop)
`define MWS_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ----- hw/rtl/mws2d_pkg.sv -----
// ----------------------------------------------------------------------------
// mws2d_pkg
// Field widths, register indexes, reset values and defaults for the
// k-by-k maximum window sum block.
// ----------------------------------------------------------------------------
package mws2d_pkg;

    // fixed field widths
    localparam int ELEM_W    = 16;
    localparam int SUM_W     = 32;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 4;

    // parameter defaults
    localparam int MAX_SIDE_DEF   = 256;
    localparam int VALUE_BITS_DEF = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIDE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIDE = CFG_IDX_W'(1);

    // register reset values
    localparam logic [CFG_W-1:0] GRID_SIDE_RST   = CFG_W'(256);
    localparam logic [CFG_W-1:0] WINDOW_SIDE_RST = CFG_W'(1);

    // result queue depth, power of two
    localparam int RES_DEPTH = 8;

endpackage

// ----- hw/rtl/max_window_sum_2d.sv -----
// ----------------------------------------------------------------------------
// max_window_sum_2d
// Largest k-by-k window sum of a square grid streamed in row-major order,
// using a line store, per-column running sums and a horizontal running sum.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake               payload
//  -------   ---------  ----------------------  -------------------------------
//  cfg       in         i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//  element   in         i_valid/o_ready         i_element_value
//  result    out        o_valid/i_ready         o_best_sum, o_no_window
//
//  One element beat per cycle. Five register stages: accept with line store
//  and column sum reads, column sum update, window sum update, best compare,
//  saturation into an eight-entry result queue. No clearing pass after
//  reset: column sums use a fill count. o_ready drops only while eight
//  results are queued or in flight; the result side never stalls the
//  datapath.
//
`include "max_window_sum_2d_defines.svh"

module max_window_sum_2d #(
    parameter int MAX_SIDE   = mws2d_pkg::MAX_SIDE_DEF,
    parameter int VALUE_BITS = mws2d_pkg::VALUE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mws2d_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mws2d_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [mws2d_pkg::ELEM_W-1:0]   i_element_value,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic signed [mws2d_pkg::SUM_W-1:0]    o_best_sum,
    output logic                                  o_no_window
);
    import mws2d_pkg::*;

    localparam int LOG_SIDE   = $clog2(MAX_SIDE);
    localparam int IDX_W      = (LOG_SIDE > 0) ? LOG_SIDE : 1;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int CMP_W      = ((SIDE_W > CFG_W) ? SIDE_W : CFG_W) + 1;
    localparam int HIST_AW    = 2 * IDX_W;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int CS_W       = VALUE_BITS + LOG_SIDE + 1;
    localparam int WS_W       = CS_W + 2 * LOG_SIDE + 1;
    localparam int SAT_W      = (WS_W > SUM_W) ? WS_W : SUM_W + 1;
    localparam int EXT_W      = (VALUE_BITS > ELEM_W) ? VALUE_BITS : ELEM_W;
    localparam int CRED_W     = $clog2(RES_DEPTH + 1);
    localparam int PTR_W      = $clog2(RES_DEPTH);

    localparam logic signed [WS_W-1:0]  WS_MIN  = {1'b1, {(WS_W - 1){1'b0}}};
    localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sh0000_0000_7FFF_FFFF);
    localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sh0000_0000_8000_0000);

    typedef struct packed {
        logic load;       // first row: column sum is loaded
        logic sub_hist;   // drop the element k rows above
        logic active;     // k rows present
        logic col0;       // row start: horizontal sum restarts
        logic sub_cs;     // drop the column sum k columns back
        logic cmp;        // a full window ends here
        logic last;       // last element of the grid
        logic nowin;      // window larger than grid
    } t_item_flags;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_grid_side;
    logic [CFG_W-1:0] r_window_side;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side   <= GRID_SIDE_RST;
            r_window_side <= WINDOW_SIDE_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_GRID_SIDE) begin
                r_grid_side <= i_cfg_data;
            end else if (i_cfg_index == CFG_WINDOW_SIDE) begin
                r_window_side <= i_cfg_data;
            end
        end
    end

    logic [SIDE_W-1:0] w_side;
    logic [CFG_W-1:0]  w_win;

    always_comb begin
        if (r_grid_side == '0) begin
            w_side = SIDE_W'(1);
        end else if (32'(r_grid_side) > 32'(MAX_SIDE)) begin
            w_side = SIDE_W'(MAX_SIDE);
        end else begin
            w_side = SIDE_W'(r_grid_side);
        end
    end

    assign w_win = (r_window_side == '0) ? CFG_W'(1) : r_window_side;

    // ------------------------------------------------------------------
    // accept stage: position, flags, line store
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]  r_row;
    logic [IDX_W-1:0]  r_col;
    logic [CRED_W-1:0] r_cred;
    logic              w_in_acc;

    logic [CMP_W-1:0] w_ie, w_je, w_ne, w_ke;
    t_item_flags      w_flags;
    logic             w_end_row;
    logic [IDX_W-1:0] w_hist_row;
    logic [IDX_W-1:0] w_col_b;

    logic [EXT_W-1:0]             w_ext;
    logic signed [VALUE_BITS-1:0] w_value;

    assign w_ext   = EXT_W'($unsigned(i_element_value));
    assign w_value = $signed(w_ext[VALUE_BITS-1:0]);

    assign o_ready  = (r_cred != CRED_W'(RES_DEPTH));
    assign w_in_acc = i_valid && o_ready;

    assign w_ie = CMP_W'(r_row);
    assign w_je = CMP_W'(r_col);
    assign w_ne = CMP_W'(w_side);
    assign w_ke = CMP_W'(w_win);

    assign w_end_row        = (w_je + CMP_W'(1)) >= w_ne;
    assign w_flags.load     = (r_row == '0);
    assign w_flags.sub_hist = w_ie >= w_ke;
    assign w_flags.active   = (w_ie + CMP_W'(1)) >= w_ke;
    assign w_flags.col0     = (r_col == '0);
    assign w_flags.sub_cs   = w_je >= w_ke;
    assign w_flags.cmp      = (w_je + CMP_W'(1)) >= w_ke;
    assign w_flags.last     = w_end_row && ((w_ie + CMP_W'(1)) >= w_ne);
    assign w_flags.nowin    = w_ke > w_ne;

    // only meaningful when the matching subtract flag is set
    assign w_hist_row = r_row - w_ke[IDX_W-1:0];
    assign w_col_b    = r_col - w_ke[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_in_acc) begin
            if (w_end_row) begin
                r_col <= '0;
                r_row <= w_flags.last ? '0 : r_row + IDX_W'(1);
            end else begin
                r_col <= r_col + IDX_W'(1);
            end
        end
    end

    logic signed [VALUE_BITS-1:0] r_hist [HIST_DEPTH];
    logic signed [VALUE_BITS-1:0] r_hist_rd;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_hist[{r_row, r_col}] <= w_value;
            r_hist_rd              <= r_hist[{w_hist_row, r_col}];
        end
    end

    // ------------------------------------------------------------------
    // column sum store, fill count marks written columns
    // ------------------------------------------------------------------
    logic signed [CS_W-1:0] r_cs [MAX_SIDE];
    logic signed [CS_W-1:0] r_cs_rd_a;
    logic signed [CS_W-1:0] r_cs_rd_b;
    logic [SIDE_W-1:0]      r_fill;

    logic                   r_s1_valid;
    t_item_flags            r_s1_flags;
    logic signed [VALUE_BITS-1:0] r_s1_value;
    logic [IDX_W-1:0]       r_s1_col;
    logic [IDX_W-1:0]       r_s1_col_b;
    logic                   r_s1_ok_a;

    logic signed [CS_W-1:0] w_cs_base;
    logic signed [CS_W-1:0] w_cs_value;
    logic signed [CS_W-1:0] w_cs_drop;
    logic signed [CS_W-1:0] w_cs_new;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_cs[r_s1_col] <= w_cs_new;
        end
        if (w_in_acc) begin
            r_cs_rd_a <= r_cs[r_col];
        end
        r_cs_rd_b <= r_cs[r_s1_col_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (r_s1_valid && (SIDE_W'(r_s1_col) >= r_fill)) begin
            r_fill <= SIDE_W'(r_s1_col) + SIDE_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // stage 1: column sum update
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_flags <= w_flags;
            r_s1_value <= w_value;
            r_s1_col   <= r_col;
            r_s1_col_b <= w_col_b;
            r_s1_ok_a  <= SIDE_W'(r_col) < r_fill;
        end
    end

    assign w_cs_value = CS_W'(r_s1_value);
    assign w_cs_base  = (r_s1_flags.load || !r_s1_ok_a) ? '0 : r_cs_rd_a;
    assign w_cs_drop  = r_s1_flags.sub_hist ? CS_W'(r_hist_rd) : '0;
    assign w_cs_new   = w_cs_base + w_cs_value - w_cs_drop;

    // ------------------------------------------------------------------
    // stage 2: horizontal window sum
    // ------------------------------------------------------------------
    logic                   r_s2_valid;
    t_item_flags            r_s2_flags;
    logic signed [CS_W-1:0] r_s2_cs;
    logic                   r_s2_ok_b;
    logic signed [WS_W-1:0] r_ws;

    logic signed [WS_W-1:0] w_ws_base;
    logic signed [WS_W-1:0] w_ws_add;
    logic signed [WS_W-1:0] w_ws_drop;
    logic signed [WS_W-1:0] w_ws_calc;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_flags <= r_s1_flags;
            r_s2_cs    <= w_cs_new;
            r_s2_ok_b  <= SIDE_W'(r_s1_col_b) < r_fill;
        end
    end

    assign w_ws_base = r_s2_flags.col0 ? '0 : r_ws;
    assign w_ws_add  = WS_W'(r_s2_cs);
    assign w_ws_drop = (r_s2_flags.sub_cs && r_s2_ok_b) ? WS_W'(r_cs_rd_b) : '0;
    assign w_ws_calc = w_ws_base + w_ws_add - w_ws_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= '0;
        end else if (r_s2_valid) begin
            if (r_s2_flags.last) begin
                r_ws <= '0;
            end else if (r_s2_flags.active) begin
                r_ws <= w_ws_calc;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 3: best compare
    // ------------------------------------------------------------------
    logic                   r_s3_valid;
    logic signed [WS_W-1:0] r_s3_sum;
    logic                   r_s3_cmp;
    logic                   r_s3_last;
    logic                   r_s3_nowin;
    logic signed [WS_W-1:0] r_best;
    logic signed [WS_W-1:0] w_best_new;

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_s3_sum   <= w_ws_calc;
            r_s3_cmp   <= r_s2_flags.active && r_s2_flags.cmp;
            r_s3_last  <= r_s2_flags.last;
            r_s3_nowin <= r_s2_flags.nowin;
        end
    end

    assign w_best_new = (r_s3_cmp && (r_s3_sum > r_best)) ? r_s3_sum : r_best;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= WS_MIN;
        end else if (r_s3_valid) begin
            r_best <= r_s3_last ? WS_MIN : w_best_new;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: saturate, push into result queue
    // ------------------------------------------------------------------
    logic                    r_s4_valid;
    logic signed [WS_W-1:0]  r_s4_best;
    logic                    r_s4_nowin;
    logic signed [SAT_W-1:0] w_best_wide;
    logic signed [SAT_W-1:0] w_best_sat;
    logic signed [SUM_W-1:0] w_res_sum;

    always_ff @(posedge i_clk) begin
        if (r_s3_valid && r_s3_last) begin
            r_s4_best  <= w_best_new;
            r_s4_nowin <= r_s3_nowin;
        end
    end

    assign w_best_wide = SAT_W'(r_s4_best);

    always_comb begin
        if (w_best_wide > SAT_MAX) begin
            w_best_sat = SAT_MAX;
        end else if (w_best_wide < SAT_MIN) begin
            w_best_sat = SAT_MIN;
        end else begin
            w_best_sat = w_best_wide;
        end
    end

    assign w_res_sum = r_s4_nowin ? '0 : w_best_sat[SUM_W-1:0];

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_in_acc;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid && r_s3_last;
        end
    end

    // ------------------------------------------------------------------
    // result queue and credit count
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] r_res_sum   [RES_DEPTH];
    logic                    r_res_nowin [RES_DEPTH];
    logic [PTR_W-1:0]        r_wr_ptr;
    logic [PTR_W-1:0]        r_rd_ptr;
    logic [CRED_W-1:0]       r_fifo_cnt;
    logic                    w_push;
    logic                    w_pop;
    logic                    w_take;

    assign w_push = r_s4_valid;
    assign w_pop  = o_valid && i_ready;
    assign w_take = w_in_acc && w_flags.last;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_res_sum[r_wr_ptr]   <= w_res_sum;
            r_res_nowin[r_wr_ptr] <= r_s4_nowin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_fifo_cnt <= '0;
            r_cred     <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            // queue fill and credits move independently on push, pop, take
            if (w_push && !w_pop) begin
                r_fifo_cnt <= r_fifo_cnt + CRED_W'(1);
            end else if (w_pop && !w_push) begin
                r_fifo_cnt <= r_fifo_cnt - CRED_W'(1);
            end
            if (w_take && !w_pop) begin
                r_cred <= r_cred + CRED_W'(1);
            end else if (w_pop && !w_take) begin
                r_cred <= r_cred - CRED_W'(1);
            end
        end
    end

    assign o_valid     = (r_fifo_cnt != '0);
    assign o_best_sum  = r_res_sum[r_rd_ptr];
    assign o_no_window = r_res_nowin[r_rd_ptr];

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `MWS_ASSERT(a_cred_covers_queue, i_clk, i_rst_n, r_fifo_cnt <= r_cred)
    `MWS_ASSERT(a_push_has_room, i_clk, i_rst_n, w_push |-> (r_fifo_cnt != CRED_W'(RES_DEPTH)))
    `MWS_ASSERT(a_grid_end_clears_pos, i_clk, i_rst_n, w_take |=> (r_row == '0 && r_col == '0))

endmodule
